### rtl/core/smm_pkg.sv
// Shared types and constants for the stream min/max/mean/run block.
package smm_pkg;

  localparam int unsigned THR_W      = 20;
  localparam int unsigned COUNT_W    = 15;
  localparam int unsigned POS_OUT_W  = 14;
  localparam int unsigned MEAN_W     = 20;
  localparam logic [THR_W-1:0] THR_RESET = 20'd500;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QFILL_W     = 3;

  // Per-set result fields, already cut to their output widths
  typedef struct packed {
    logic [COUNT_W-1:0]   record_count;
    logic [POS_OUT_W-1:0] min_position;
    logic [POS_OUT_W-1:0] max_position;
    logic                 run_exists;
    logic [POS_OUT_W-1:0] run_first;
    logic [POS_OUT_W-1:0] run_last;
    logic                 set_empty;
    logic                 count_overflow;
  } res_fields_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_HOLD
  } div_state_t;

endpackage

### rtl/core/smm_front.sv
// Front end: threshold register, sample acceptance and classification.
module smm_front
  import smm_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  logic [VALUE_BITS-1:0] sample_value,
  input  logic                  last_in_set,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [THR_W-1:0]      cfg_data,
  input  logic                  q_full,
  output logic                  push,
  output logic [VALUE_BITS+1:0] push_data
);

  localparam int unsigned CMP_W = (VALUE_BITS > THR_W) ? VALUE_BITS : THR_W;

  logic [THR_W-1:0] threshold;
  logic             above;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  assign cfg_ready    = 1'b1;
  assign sample_stall = q_full;
  assign push         = sample_valid && !sample_stall;
  assign above        = CMP_W'(sample_value) > CMP_W'(threshold);
  assign push_data    = {sample_value, last_in_set, above};

endmodule

### rtl/core/smm_queue.sv
// Short register queue between the front end and the accumulator.
module smm_queue
  import smm_pkg::*;
#(
  parameter int unsigned DATA_W = 22
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output logic [DATA_W-1:0] q_data
);

  logic [DATA_W-1:0]  slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign full    = fill == QFILL_W'(QUEUE_DEPTH);
  assign q_valid = fill != '0;
  assign q_data  = slots[rd_ptr];

endmodule

### rtl/core/smm_back.sv
// Back end: per-set min, max, sum and longest run tracking.
module smm_back
  import smm_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 20,
  parameter int unsigned MAX_ITEMS  = 16384
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_valid,
  input  logic [VALUE_BITS+1:0]                   q_data,
  output logic                                    pop,
  input  logic                                    div_busy,
  output logic                                    req_valid,
  output res_fields_t                             req_fields,
  output logic [VALUE_BITS+$clog2(MAX_ITEMS+1)-1:0] req_sum,
  output logic [$clog2(MAX_ITEMS+1)-1:0]          req_count
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned POS_W = $clog2(MAX_ITEMS);
  localparam int unsigned SUM_W = VALUE_BITS + CNT_W;

  logic [VALUE_BITS-1:0] value;
  logic                  last;
  logic                  above;

  logic [CNT_W-1:0]      item_count, item_count_upd, item_count_next;
  logic [VALUE_BITS-1:0] low_value, low_value_upd, low_value_next;
  logic [POS_W-1:0]      low_position, low_position_upd, low_position_next;
  logic [VALUE_BITS-1:0] high_value, high_value_upd, high_value_next;
  logic [POS_W-1:0]      high_position, high_position_upd, high_position_next;
  logic [SUM_W-1:0]      running_sum, running_sum_upd, running_sum_next;
  logic                  inside_run, inside_run_upd, inside_run_next;
  logic [POS_W-1:0]      current_run_start, current_run_start_upd, current_run_start_next;
  logic [CNT_W-1:0]      best_run_length, best_run_length_upd, best_run_length_next;
  logic [POS_W-1:0]      best_run_start, best_run_start_upd, best_run_start_next;
  logic [POS_W-1:0]      best_run_end, best_run_end_upd, best_run_end_next;
  logic                  overflow_seen, overflow_seen_upd, overflow_seen_next;

  logic                  counted;
  logic [POS_W-1:0]      idx;
  logic                  offer;
  logic [POS_W-1:0]      offer_first;
  logic [POS_W-1:0]      offer_last;
  logic [CNT_W-1:0]      offer_len;
  logic                  empty;
  logic                  has_run;

  assign {value, last, above} = q_data;

  // A set's closing beat waits while the divider still owns the previous set
  assign pop       = q_valid && (!last || !div_busy);
  assign req_valid = pop && last;

  assign counted = item_count < CNT_W'(MAX_ITEMS);
  assign idx     = item_count[POS_W-1:0];

  always_comb begin
    item_count_upd        = item_count;
    low_value_upd         = low_value;
    low_position_upd      = low_position;
    high_value_upd        = high_value;
    high_position_upd     = high_position;
    running_sum_upd       = running_sum;
    inside_run_upd        = inside_run;
    current_run_start_upd = current_run_start;
    overflow_seen_upd     = overflow_seen;
    offer                 = 1'b0;
    offer_first           = current_run_start;
    offer_last            = idx;

    if (counted) begin
      if (item_count == '0 || value < low_value) begin
        low_value_upd    = value;
        low_position_upd = idx;
      end
      if (item_count == '0 || value > high_value) begin
        high_value_upd    = value;
        high_position_upd = idx;
      end
      running_sum_upd = running_sum + SUM_W'(value);
      item_count_upd  = item_count + 1'b1;
      if (above) begin
        if (!inside_run) begin
          inside_run_upd        = 1'b1;
          current_run_start_upd = idx;
        end
      end else if (inside_run) begin
        offer          = 1'b1;
        offer_last     = idx - 1'b1;
        inside_run_upd = 1'b0;
      end
    end else begin
      overflow_seen_upd = 1'b1;
    end

    // Run still open at the end of the set is closed at the last counted index
    if (last && inside_run_upd) begin
      offer          = 1'b1;
      offer_first    = current_run_start_upd;
      offer_last     = POS_W'(item_count_upd - 1'b1);
      inside_run_upd = 1'b0;
    end
  end

  assign offer_len = CNT_W'(offer_last) - CNT_W'(offer_first) + 1'b1;

  always_comb begin
    best_run_length_upd = best_run_length;
    best_run_start_upd  = best_run_start;
    best_run_end_upd    = best_run_end;
    if (offer && offer_len > best_run_length) begin
      best_run_length_upd = offer_len;
      best_run_start_upd  = offer_first;
      best_run_end_upd    = offer_last;
    end
  end

  always_comb begin
    if (pop && last) begin
      item_count_next        = '0;
      low_value_next         = '1;
      low_position_next      = '0;
      high_value_next        = '0;
      high_position_next     = '0;
      running_sum_next       = '0;
      inside_run_next        = 1'b0;
      current_run_start_next = '0;
      best_run_length_next   = '0;
      best_run_start_next    = '0;
      best_run_end_next      = '0;
      overflow_seen_next     = 1'b0;
    end else if (pop) begin
      item_count_next        = item_count_upd;
      low_value_next         = low_value_upd;
      low_position_next      = low_position_upd;
      high_value_next        = high_value_upd;
      high_position_next     = high_position_upd;
      running_sum_next       = running_sum_upd;
      inside_run_next        = inside_run_upd;
      current_run_start_next = current_run_start_upd;
      best_run_length_next   = best_run_length_upd;
      best_run_start_next    = best_run_start_upd;
      best_run_end_next      = best_run_end_upd;
      overflow_seen_next     = overflow_seen_upd;
    end else begin
      item_count_next        = item_count;
      low_value_next         = low_value;
      low_position_next      = low_position;
      high_value_next        = high_value;
      high_position_next     = high_position;
      running_sum_next       = running_sum;
      inside_run_next        = inside_run;
      current_run_start_next = current_run_start;
      best_run_length_next   = best_run_length;
      best_run_start_next    = best_run_start;
      best_run_end_next      = best_run_end;
      overflow_seen_next     = overflow_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count        <= '0;
      low_value         <= '1;
      low_position      <= '0;
      high_value        <= '0;
      high_position     <= '0;
      running_sum       <= '0;
      inside_run        <= 1'b0;
      current_run_start <= '0;
      best_run_length   <= '0;
      best_run_start    <= '0;
      best_run_end      <= '0;
      overflow_seen     <= 1'b0;
    end else begin
      item_count        <= item_count_next;
      low_value         <= low_value_next;
      low_position      <= low_position_next;
      high_value        <= high_value_next;
      high_position     <= high_position_next;
      running_sum       <= running_sum_next;
      inside_run        <= inside_run_next;
      current_run_start <= current_run_start_next;
      best_run_length   <= best_run_length_next;
      best_run_start    <= best_run_start_next;
      best_run_end      <= best_run_end_next;
      overflow_seen     <= overflow_seen_next;
    end
  end

  assign empty   = item_count_upd == '0;
  assign has_run = best_run_length_upd != '0;

  always_comb begin
    req_fields.record_count   = COUNT_W'(item_count_upd);
    req_fields.min_position   = empty ? '0 : POS_OUT_W'(low_position_upd);
    req_fields.max_position   = empty ? '0 : POS_OUT_W'(high_position_upd);
    req_fields.run_exists     = has_run;
    req_fields.run_first      = has_run ? POS_OUT_W'(best_run_start_upd) : '0;
    req_fields.run_last       = has_run ? POS_OUT_W'(best_run_end_upd) : '0;
    req_fields.set_empty      = empty;
    req_fields.count_overflow = overflow_seen_upd;
  end

  assign req_sum   = running_sum_upd;
  assign req_count = item_count_upd;

endmodule

### rtl/core/smm_div.sv
// Bit-serial mean divider and result output register.
module smm_div
  import smm_pkg::*;
#(
  parameter int unsigned SUM_W = 35,
  parameter int unsigned CNT_W = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  res_fields_t       req_fields,
  input  logic [SUM_W-1:0]  req_sum,
  input  logic [CNT_W-1:0]  req_count,
  output logic              busy,
  output logic              result_valid,
  input  logic              result_stall,
  output res_fields_t       out_fields,
  output logic [MEAN_W-1:0] mean_value
);

  localparam int unsigned STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  div_state_t        state, state_next;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvsr;
  logic [CNT_W:0]    trial;
  logic              ge;

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (start) state_next = DIV_RUN;
      DIV_RUN:  if (step == '0) state_next = DIV_HOLD;
      DIV_HOLD: if (!result_stall) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    result_valid = 1'b0;
    case (state)
      DIV_IDLE: busy = 1'b0;
      DIV_RUN:  busy = 1'b1;
      DIV_HOLD: result_valid = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Restoring division, one quotient bit per cycle
  assign trial = {rem, quo[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      quo        <= req_sum;
      rem        <= '0;
      dvsr       <= req_count;
      step       <= STEP_W'(SUM_W - 1);
      out_fields <= req_fields;
    end else if (state == DIV_RUN) begin
      quo  <= {quo[SUM_W-2:0], ge};
      rem  <= ge ? CNT_W'(trial - {1'b0, dvsr}) : trial[CNT_W-1:0];
      step <= step - 1'b1;
    end
  end

  assign mean_value = out_fields.set_empty ? '0 : MEAN_W'(quo);

endmodule

### rtl/core/stream_min_max_mean_longest_run.sv
// Top level: stream statistics with min, max, mean and longest run per set.
//
// Samples come in on the sample channel (sample_valid / sample_stall), one
// beat per sample, with last_in_set on the closing beat of a set. For each
// set one beat leaves on the result channel (result_valid / result_stall)
// with the count, first min and max indices, truncated mean, bounds of the
// longest run above run_threshold (earliest on ties) and status flags.
// run_threshold is written over cfg_valid / cfg_ready; the user must write it
// only while idle, as the block itself does not enforce this.
// Throughput: one sample per cycle while the four-entry queue has room.
// After the closing beat the bit-serial mean divider computes the mean,
// then the result register presents the beat. A new set's samples keep
// streaming meanwhile; its closing beat waits in the queue until the
// divider and result register are free. While result_stall is high the
// result beat holds; once the queue fills, sample_stall rises. Reset empties
// the queue, clears all set state and loads run_threshold with 500.
module stream_min_max_mean_longest_run
  import smm_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = 16384,
  parameter int unsigned VALUE_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  logic [VALUE_BITS-1:0] sample_value,
  input  logic                  last_in_set,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [THR_W-1:0]      run_threshold,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [COUNT_W-1:0]    record_count,
  output logic [POS_OUT_W-1:0]  min_position,
  output logic [POS_OUT_W-1:0]  max_position,
  output logic [MEAN_W-1:0]     mean_value,
  output logic                  run_exists,
  output logic [POS_OUT_W-1:0]  run_first,
  output logic [POS_OUT_W-1:0]  run_last,
  output logic                  set_empty,
  output logic                  count_overflow
);

  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SUM_W  = VALUE_BITS + CNT_W;
  localparam int unsigned DATA_W = VALUE_BITS + 2;

  logic              push;
  logic [DATA_W-1:0] push_data;
  logic              q_full;
  logic              pop;
  logic              q_valid;
  logic [DATA_W-1:0] q_data;
  logic              div_busy;
  logic              req_valid;
  res_fields_t       req_fields;
  logic [SUM_W-1:0]  req_sum;
  logic [CNT_W-1:0]  req_count;
  res_fields_t       out_fields;

  smm_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_value (sample_value),
    .last_in_set  (last_in_set),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (run_threshold),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  smm_queue #(
    .DATA_W(DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  smm_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .div_busy   (div_busy),
    .req_valid  (req_valid),
    .req_fields (req_fields),
    .req_sum    (req_sum),
    .req_count  (req_count)
  );

  smm_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .start        (req_valid),
    .req_fields   (req_fields),
    .req_sum      (req_sum),
    .req_count    (req_count),
    .busy         (div_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_fields   (out_fields),
    .mean_value   (mean_value)
  );

  assign record_count   = out_fields.record_count;
  assign min_position   = out_fields.min_position;
  assign max_position   = out_fields.max_position;
  assign run_exists     = out_fields.run_exists;
  assign run_first      = out_fields.run_first;
  assign run_last       = out_fields.run_last;
  assign set_empty      = out_fields.set_empty;
  assign count_overflow = out_fields.count_overflow;

`ifndef SYNTHESIS
  // the closing beat of a set is only taken once the divider is free
  a_no_start_while_busy: assert property (
    @(posedge clk) disable iff (rst) req_valid |-> !div_busy
  ) else $error("set closed while divider busy");

  // every set holds at least its closing sample
  a_never_empty: assert property (
    @(posedge clk) disable iff (rst) result_valid |-> (!set_empty && record_count != '0)
  ) else $error("empty set reported");

  a_run_order: assert property (
    @(posedge clk) disable iff (rst) (result_valid && run_exists) |-> run_last >= run_first
  ) else $error("run bounds out of order");

  // a request moves the divider into its busy run state, with no result beat yet
  a_req_to_busy: assert property (
    @(posedge clk) disable iff (rst) req_valid |=> (div_busy && !result_valid)
  ) else $error("divider did not start");
`endif

endmodule

### test/set_summary_checker.sv
// Checker for the per-set statistics stream: predicts each set summary and compares.
module set_summary_checker
  import smm_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = 16384,
  parameter int unsigned VALUE_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  input  logic                  sample_stall,
  input  logic [VALUE_BITS-1:0] sample_value,
  input  logic                  last_in_set,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [THR_W-1:0]      run_threshold,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  logic [COUNT_W-1:0]    record_count,
  input  logic [POS_OUT_W-1:0]  min_position,
  input  logic [POS_OUT_W-1:0]  max_position,
  input  logic [MEAN_W-1:0]     mean_value,
  input  logic                  run_exists,
  input  logic [POS_OUT_W-1:0]  run_first,
  input  logic [POS_OUT_W-1:0]  run_last,
  input  logic                  set_empty,
  input  logic                  count_overflow,
  output int                    mismatches,
  output int                    sets_outstanding
);

  typedef struct packed {
    res_fields_t       stats;
    logic [MEAN_W-1:0] mean;
  } set_summary_t;

  set_summary_t expected_summaries[$];

  // running picture of the open set
  logic [THR_W-1:0]      threshold;
  int unsigned           n_counted;
  logic [VALUE_BITS-1:0] least;
  int unsigned           least_at;
  logic [VALUE_BITS-1:0] most;
  int unsigned           most_at;
  longint unsigned       total;
  logic                  in_run;
  int unsigned           run_from;
  int unsigned           best_len;
  int unsigned           best_from;
  int unsigned           best_to;
  logic                  overflowed;
  int                    sets_checked;

  task automatic report(input string what);
    if (mismatches < 40) $display("MISMATCH set %0d: %s", sets_checked, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [33:0] got,
                             input logic [33:0] want);
    if (got !== want) report($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic clear_set();
    n_counted  = 0;
    least      = '1;
    least_at   = 0;
    most       = '0;
    most_at    = 0;
    total      = 0;
    in_run     = 1'b0;
    run_from   = 0;
    best_len   = 0;
    best_from  = 0;
    best_to    = 0;
    overflowed = 1'b0;
  endtask

  // strictly longer wins, so the earliest run survives a tie
  task automatic offer_run(input int unsigned from_idx, input int unsigned to_idx);
    if (to_idx - from_idx + 1 > best_len) begin
      best_len  = to_idx - from_idx + 1;
      best_from = from_idx;
      best_to   = to_idx;
    end
  endtask

  task automatic take_sample(input logic [VALUE_BITS-1:0] v, input logic closing);
    set_summary_t    s;
    longint unsigned avg;
    if (n_counted < MAX_ITEMS) begin
      if (n_counted == 0 || v < least) begin
        least    = v;
        least_at = n_counted;
      end
      if (n_counted == 0 || v > most) begin
        most    = v;
        most_at = n_counted;
      end
      total += v;
      if (v > threshold) begin
        if (!in_run) begin
          in_run   = 1'b1;
          run_from = n_counted;
        end
      end else if (in_run) begin
        offer_run(run_from, n_counted - 1);
        in_run = 1'b0;
      end
      n_counted++;
    end else begin
      overflowed = 1'b1;
    end
    if (closing) begin
      if (in_run && n_counted > 0) offer_run(run_from, n_counted - 1);
      avg = (n_counted == 0) ? 0 : total / n_counted;
      s.stats.record_count   = n_counted[COUNT_W-1:0];
      s.stats.min_position   = (n_counted == 0) ? '0 : least_at[POS_OUT_W-1:0];
      s.stats.max_position   = (n_counted == 0) ? '0 : most_at[POS_OUT_W-1:0];
      s.stats.run_exists     = (best_len > 0);
      s.stats.run_first      = (best_len > 0) ? best_from[POS_OUT_W-1:0] : '0;
      s.stats.run_last       = (best_len > 0) ? best_to[POS_OUT_W-1:0] : '0;
      s.stats.set_empty      = (n_counted == 0);
      s.stats.count_overflow = overflowed;
      s.mean                 = avg[MEAN_W-1:0];
      expected_summaries.push_back(s);
      clear_set();
    end
  endtask

  task automatic check_result();
    set_summary_t s;
    if (expected_summaries.size() == 0) begin
      report("result beat with no set outstanding");
      return;
    end
    s = expected_summaries.pop_front();
    check_field("record_count",   record_count,   s.stats.record_count);
    check_field("min_position",   min_position,   s.stats.min_position);
    check_field("max_position",   max_position,   s.stats.max_position);
    check_field("mean_value",     mean_value,     s.mean);
    check_field("run_exists",     run_exists,     s.stats.run_exists);
    check_field("run_first",      run_first,      s.stats.run_first);
    check_field("run_last",       run_last,       s.stats.run_last);
    check_field("set_empty",      set_empty,      s.stats.set_empty);
    check_field("count_overflow", count_overflow, s.stats.count_overflow);
    sets_checked++;
  endtask

  // a threshold written on the same edge as a sample applies from the next one
  always @(posedge clk) begin
    if (rst) begin
      threshold = THR_RESET;
      clear_set();
      expected_summaries.delete();
    end else begin
      if (result_valid && !result_stall) check_result();
      if (sample_valid && !sample_stall) take_sample(sample_value, last_in_set);
      if (cfg_valid && cfg_ready) threshold = run_threshold;
    end
    sets_outstanding <= expected_summaries.size();
  end

endmodule

### test/stream_min_max_mean_longest_run_test.sv
// Testbench top: drives samples, threshold writes and result back-pressure.
module stream_min_max_mean_longest_run_test;
  import smm_pkg::*;

  localparam int unsigned MAX_ITEMS    = 16384;
  localparam int unsigned VALUE_BITS   = 20;
  localparam longint      VAL_MAX      = 1048575;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          DRAIN_GAP    = 60;
  localparam int          LONG_HOLD    = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  logic [VALUE_BITS-1:0] sample_value = '0;
  logic                  last_in_set = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [THR_W-1:0]      run_threshold = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [COUNT_W-1:0]    record_count;
  logic [POS_OUT_W-1:0]  min_position;
  logic [POS_OUT_W-1:0]  max_position;
  logic [MEAN_W-1:0]     mean_value;
  logic                  run_exists;
  logic [POS_OUT_W-1:0]  run_first;
  logic [POS_OUT_W-1:0]  run_last;
  logic                  set_empty;
  logic                  count_overflow;

  int               mismatches;
  int               sets_outstanding;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_left = 0;
  int               samples_sent = 0;
  int               sets_sent = 0;
  int               thresholds_used = 1;
  int               cycles_elapsed = 0;
  logic [THR_W-1:0] cur_thr = THR_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stream_min_max_mean_longest_run #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk, .rst, .sample_valid, .sample_stall, .sample_value, .last_in_set,
    .cfg_valid, .cfg_ready, .run_threshold, .result_valid, .result_stall,
    .record_count, .min_position, .max_position, .mean_value, .run_exists,
    .run_first, .run_last, .set_empty, .count_overflow
  );

  set_summary_checker #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) checker_i (
    .clk, .rst, .sample_valid, .sample_stall, .sample_value, .last_in_set,
    .cfg_valid, .cfg_ready, .run_threshold, .result_valid, .result_stall,
    .record_count, .min_position, .max_position, .mean_value, .run_exists,
    .run_first, .run_last, .set_empty, .count_overflow,
    .mismatches, .sets_outstanding
  );

  // result side: a long hold when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    while (cycles_elapsed < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles_elapsed++;
    end
    $display("Some tests failed");
    $finish;
  end

  // mostly hugs the threshold so runs start and stop often
  function automatic logic [VALUE_BITS-1:0] pick_value();
    int unsigned roll;
    longint      v;
    roll = $urandom_range(99);
    if (roll < 40)      v = longint'(cur_thr) + 1 + longint'($urandom_range(3));
    else if (roll < 70) v = longint'(cur_thr) - longint'($urandom_range(3));
    else if (roll < 80) v = 0;
    else if (roll < 90) v = VAL_MAX;
    else                v = longint'($urandom_range(VAL_MAX));
    if (v < 0) v = 0;
    if (v > VAL_MAX) v = VAL_MAX;
    return v[VALUE_BITS-1:0];
  endfunction

  task automatic send_sample(input logic [VALUE_BITS-1:0] v, input logic closing);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_value <= v;
    last_in_set  <= closing;
    do @(posedge clk); while (sample_stall);
    samples_sent++;
    if (closing) sets_sent++;
  endtask

  task automatic send_random_set();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(80, 40) : $urandom_range(8, 1);
    for (int i = 0; i < len; i++) send_sample(pick_value(), i == len - 1);
  endtask

  // outstanding count is registered in the checker, so it lags the closing beat
  task automatic drain_results();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (sets_outstanding != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] thr);
    cfg_valid     <= 1'b1;
    run_threshold <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_thr = thr;
    thresholds_used++;
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct,
                              input logic [THR_W-1:0] thr, input int items);
    int target;
    drain_results();
    write_threshold(thr);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    target = samples_sent + items;
    while (samples_sent < target) send_random_set();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset threshold of 500; extremes, first-of-ties, runs open at the end
    send_sample(0, 1'b0);
    send_sample(VALUE_BITS'(VAL_MAX), 1'b0);
    send_sample(501, 1'b0);
    send_sample(500, 1'b0);
    send_sample(VALUE_BITS'(VAL_MAX), 1'b0);
    send_sample(0, 1'b1);
    send_sample(VALUE_BITS'(VAL_MAX), 1'b1);
    send_sample(0, 1'b1);
    send_sample(600, 1'b0);
    send_sample(600, 1'b0);
    send_sample(0, 1'b0);
    send_sample(700, 1'b0);
    send_sample(700, 1'b1);
    send_sample(600, 1'b0);
    send_sample(0, 1'b0);
    send_sample(700, 1'b0);
    send_sample(700, 1'b0);
    send_sample(700, 1'b1);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b1);

    // results held back while the sender keeps going, so the queue fills
    drain_results();
    hold_left <= LONG_HOLD;
    for (int s = 0; s < 12; s++)
      for (int i = 0; i < 3; i++) send_sample(pick_value(), i == 2);

    random_phase(26, 51, '0, 125);
    random_phase(26, 51, THR_W'($urandom_range(1000, 1047000)), 125);
    random_phase(51, 26, THR_W'(VAL_MAX), 125);
    random_phase(51, 26, THR_W'($urandom_range(0, 4000)), 125);
    random_phase(0, 0, THR_W'($urandom_range(1000, 1047000)), 125);
    random_phase(0, 0, THR_W'(VAL_MAX - 1), 125);

    drain_results();
    $display("Sent %0d samples in %0d sets under %0d threshold values,",
             samples_sent, sets_sent, thresholds_used);
    $display("with runs open at set ends, tied extremes and long result back-pressure.");
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
rtl/core/smm_pkg.sv
rtl/core/smm_front.sv
rtl/core/smm_queue.sv
rtl/core/smm_back.sv
rtl/core/smm_div.sv
rtl/core/stream_min_max_mean_longest_run.sv
test/set_summary_checker.sv
test/stream_min_max_mean_longest_run_test.sv
